### design/tip_pkg.sv
package tip_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int DIMENSIONS_DEF  = 3;
	localparam int MAX_DIMS        = 3;
	localparam int INDEX_W         = 32;
	localparam int POS_W           = 17;
	localparam int CFG_DATA_W      = 48;
	localparam int CFG_INDEX_W     = 3;

	// register map
	localparam logic [CFG_INDEX_W-1:0] REG_START_I = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_START_J = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_START_K = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_END_I   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_END_J   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_END_K   = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_STEPS   = 3'd6;

	localparam logic [CFG_DATA_W-1:0] STEPS_RESET = 48'h0001_0001_0001;

	// one block request on its way from the front to the back
	typedef struct packed {
		logic               valid;
		logic [INDEX_W-1:0] block_index;
	} item_t;

endpackage

### design/tile_index_to_position_top.sv
// A request accepted by the front passes through one queue slot, 32 quotient
// stages and one position stage per dimension, and then the output register.
// Throughput: one request per cycle while busy is low; the receiver cannot
// stall, so results never back up.
// After every register write busy stays high while the per-dimension counts are rebuilt.
// Reset (arst_n low, asynchronous): starts and ends 0, all steps 1, counts 0, pipeline empty.
module tile_index_to_position_top #(
	parameter int COORD_WIDTH = tip_pkg::COORD_WIDTH_DEF,
	parameter int DIMENSIONS  = tip_pkg::DIMENSIONS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [tip_pkg::INDEX_W-1:0]     block_index,
	output logic                            result_valid,
	output logic [tip_pkg::POS_W-1:0]       pos_i,
	output logic [tip_pkg::POS_W-1:0]       pos_j,
	output logic [tip_pkg::POS_W-1:0]       pos_k,
	output logic                            done_res,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tip_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tip_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import tip_pkg::*;

	// fixed request-to-result distance, in clock edges
	localparam int LAT = 33 * DIMENSIONS + 2;

	item_t                                   push;
	item_t                                   head;
	logic                                    q_full;
	logic [DIMENSIONS-1:0][COORD_WIDTH-1:0]  cnt;
	logic [DIMENSIONS-1:0][COORD_WIDTH-1:0]  lo;
	logic [DIMENSIONS-1:0][COORD_WIDTH-1:0]  st;
	logic [MAX_DIMS-1:0][POS_W-1:0]          pos;

	// Front: hold the register file, rebuild the per-dimension counts after any
	// write, and take a request whenever the count unit is idle and the queue is not full.
	tip_front #(
		.CW   (COORD_WIDTH),
		.DIMS (DIMENSIONS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.block_index (block_index),
		.busy        (busy),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_full      (q_full),
		.push        (push),
		.cnt         (cnt),
		.lo          (lo),
		.st          (st)
	);

	// Short queue between front and back; the back drains it every cycle.
	tip_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.head   (head),
		.full   (q_full)
	);

	// Back: split the block number mixed-radix, i fastest, one quotient bit per
	// stage, then scale each remainder by its step and add the start.
	tip_back #(
		.CW   (COORD_WIDTH),
		.DIMS (DIMENSIONS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.cnt       (cnt),
		.lo        (lo),
		.st        (st),
		.res_valid (result_valid),
		.pos       (pos),
		.done      (done_res)
	);

	assign pos_i = pos[0];
	assign pos_j = pos[1];
	assign pos_k = pos[2];

`ifndef NO_ASSERTIONS
	// every accepted request comes out at the request-to-result distance LAT
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT result_valid)
		else $error("request result missing at fixed latency");

	// a register write must block requests while counts are rebuilt
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> busy)
		else $error("request window open right after register write");
`endif

endmodule

### design/tip_front.sv
module tip_front #(
	parameter int CW   = tip_pkg::COORD_WIDTH_DEF,
	parameter int DIMS = tip_pkg::DIMENSIONS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [tip_pkg::INDEX_W-1:0]       block_index,
	output logic                              busy,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tip_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [tip_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              q_full,
	output tip_pkg::item_t                    push,
	output logic [DIMS-1:0][CW-1:0]           cnt,
	output logic [DIMS-1:0][CW-1:0]           lo,
	output logic [DIMS-1:0][CW-1:0]           st
);
	import tip_pkg::*;

	localparam int DW    = (DIMS > 1) ? $clog2(DIMS) : 1;
	localparam int BW    = $clog2(CW + 2);
	localparam int EXT_W = CFG_DATA_W + MAX_DIMS * CW;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;

	logic [MAX_DIMS-1:0][CW-1:0] start_q;
	logic [MAX_DIMS-1:0][CW-1:0] end_q;
	logic [CFG_DATA_W-1:0]       steps_q;
	logic [EXT_W-1:0]            steps_ext;
	logic [DIMS-1:0][CW-1:0]     cnt_q;
	logic [DIMS-1:0][CW:0]       num;

	logic [1:0]    state_q;
	logic [DW-1:0] dim_q;
	logic [BW-1:0] bit_q;
	logic [CW:0]   n_q;
	logic [CW-1:0] r_q;

	logic [CW:0]   trial;
	logic [CW:0]   trial_sub;
	logic [CW-1:0] cur_st;
	logic          ge;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			end_q   <= '0;
			steps_q <= STEPS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_START_I: start_q[0] <= cfg_data[CW-1:0];
				REG_START_J: start_q[1] <= cfg_data[CW-1:0];
				REG_START_K: start_q[2] <= cfg_data[CW-1:0];
				REG_END_I:   end_q[0]   <= cfg_data[CW-1:0];
				REG_END_J:   end_q[1]   <= cfg_data[CW-1:0];
				REG_END_K:   end_q[2]   <= cfg_data[CW-1:0];
				REG_STEPS:   steps_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign steps_ext = EXT_W'(steps_q);

	for (genvar d = 0; d < DIMS; d++) begin : g_dim
		logic [CW-1:0] raw;
		assign raw   = steps_ext[d*CW +: CW];
		assign st[d] = (raw == '0) ? CW'(1) : raw;
		assign lo[d] = start_q[d];
		// ceil(diff / step) as floor((diff + step - 1) / step); empty range gives 0
		assign num[d] = (end_q[d] > start_q[d]) ?
			({1'b0, end_q[d] - start_q[d]} + {1'b0, st[d]} - (CW+1)'(1)) : '0;
	end

	assign cnt = cnt_q;

	// count unit: one restoring step per cycle in ST_RUN, dimensions in turn
	assign cur_st    = st[dim_q];
	assign trial     = {r_q, n_q[CW]};
	assign trial_sub = trial - {1'b0, cur_st};
	assign ge        = trial >= {1'b0, cur_st};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dim_q   <= '0;
			bit_q   <= '0;
			cnt_q   <= '0;
		end else if (cfg_valid) begin
			state_q <= ST_LOAD;
			dim_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: ;
				ST_LOAD: begin
					state_q <= ST_RUN;
					bit_q   <= '0;
				end
				ST_RUN: begin
					bit_q <= bit_q + BW'(1);
					if (bit_q == BW'(CW)) begin
						cnt_q[dim_q] <= {n_q[CW-2:0], ge};
						if (dim_q == DW'(DIMS - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							dim_q   <= dim_q + DW'(1);
							state_q <= ST_LOAD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			n_q <= num[dim_q];
			r_q <= '0;
		end else begin
			n_q <= {n_q[CW-1:0], ge};
			r_q <= ge ? trial_sub[CW-1:0] : trial[CW-1:0];
		end
	end

	assign busy             = (state_q != ST_IDLE) || q_full;
	assign push.valid       = start && !busy;
	assign push.block_index = block_index;

endmodule

### design/tip_queue.sv
module tip_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  tip_pkg::item_t push,
	output tip_pkg::item_t head,
	output logic           full
);
	import tip_pkg::*;

	logic [INDEX_W-1:0] mem_q [2];
	logic               wr_q;
	logic               rd_q;
	logic [1:0]         count_q;
	logic               pop;

	// the back never stalls: drain one entry every cycle that the queue is not empty
	assign pop  = count_q != 2'd0;
	assign full = count_q == 2'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push.valid) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			count_q <= count_q + 2'(push.valid) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) mem_q[wr_q] <= push.block_index;
	end

	assign head.valid       = pop;
	assign head.block_index = mem_q[rd_q];

endmodule

### design/tip_back.sv
module tip_back #(
	parameter int CW   = tip_pkg::COORD_WIDTH_DEF,
	parameter int DIMS = tip_pkg::DIMENSIONS_DEF
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  tip_pkg::item_t                                     head,
	input  logic [DIMS-1:0][CW-1:0]                            cnt,
	input  logic [DIMS-1:0][CW-1:0]                            lo,
	input  logic [DIMS-1:0][CW-1:0]                            st,
	output logic                                               res_valid,
	output logic [tip_pkg::MAX_DIMS-1:0][tip_pkg::POS_W-1:0]   pos,
	output logic                                               done
);
	import tip_pkg::*;

	localparam int NB = INDEX_W;
	localparam int EW = (CW > POS_W) ? CW : POS_W;

	logic                                v_s [DIMS][NB+1];
	logic [INDEX_W-1:0]                  w_s [DIMS][NB+1];
	logic [CW-1:0]                       r_s [DIMS][NB];
	logic [MAX_DIMS-1:0][POS_W-1:0]      p_s [DIMS][NB+1];

	logic                                res_valid_q;
	logic [MAX_DIMS-1:0][POS_W-1:0]      pos_q;
	logic                                done_q;

	for (genvar d = 0; d < DIMS; d++) begin : g_dim
		logic                           ent_v;
		logic [INDEX_W-1:0]             ent_w;
		logic [MAX_DIMS-1:0][POS_W-1:0] ent_p;
		logic                           nz;

		if (d == 0) begin : g_first
			assign ent_v = head.valid;
			assign ent_w = head.block_index;
			assign ent_p = '0;
		end else begin : g_next
			assign ent_v = v_s[d-1][NB];
			assign ent_w = w_s[d-1][NB];
			assign ent_p = p_s[d-1][NB];
		end

		assign nz = cnt[d] != '0;

		// one quotient bit per stage; with a zero count the word just rotates back
		for (genvar b = 0; b < NB; b++) begin : g_bit
			logic                           src_v;
			logic [INDEX_W-1:0]             src_w;
			logic [CW-1:0]                  src_r;
			logic [MAX_DIMS-1:0][POS_W-1:0] src_p;
			logic [CW:0]                    trial;
			logic [CW:0]                    trial_sub;
			logic                           ge;
			logic                           qb;

			if (b == 0) begin : g_in
				assign src_v = ent_v;
				assign src_w = ent_w;
				assign src_r = '0;
				assign src_p = ent_p;
			end else begin : g_chain
				assign src_v = v_s[d][b-1];
				assign src_w = w_s[d][b-1];
				assign src_r = r_s[d][b-1];
				assign src_p = p_s[d][b-1];
			end

			assign trial     = {src_r, src_w[INDEX_W-1]};
			assign trial_sub = trial - {1'b0, cnt[d]};
			assign ge        = trial >= {1'b0, cnt[d]};
			assign qb        = nz ? ge : src_w[INDEX_W-1];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) v_s[d][b] <= 1'b0;
				else         v_s[d][b] <= src_v;
			end

			always_ff @(posedge clk) begin
				w_s[d][b] <= {src_w[INDEX_W-2:0], qb};
				p_s[d][b] <= src_p;
				if (!nz)     r_s[d][b] <= '0;
				else if (ge) r_s[d][b] <= trial_sub[CW-1:0];
				else         r_s[d][b] <= trial[CW-1:0];
			end
		end

		// position stage: start + remainder * step, kept to the output width
		logic [EW-1:0]                  lo_e;
		logic [EW-1:0]                  r_e;
		logic [EW-1:0]                  st_e;
		logic [2*POS_W-1:0]             prod;
		logic [MAX_DIMS-1:0][POS_W-1:0] p_new;

		assign lo_e = EW'(lo[d]);
		assign r_e  = EW'(r_s[d][NB-1]);
		assign st_e = EW'(st[d]);
		assign prod = r_e[POS_W-1:0] * st_e[POS_W-1:0];

		always_comb begin
			p_new    = p_s[d][NB-1];
			p_new[d] = lo_e[POS_W-1:0] + prod[POS_W-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[d][NB] <= 1'b0;
			else         v_s[d][NB] <= v_s[d][NB-1];
		end

		always_ff @(posedge clk) begin
			w_s[d][NB] <= w_s[d][NB-1];
			p_s[d][NB] <= p_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid_q <= 1'b0;
		else         res_valid_q <= v_s[DIMS-1][NB];
	end

	always_ff @(posedge clk) begin
		pos_q  <= p_s[DIMS-1][NB];
		done_q <= w_s[DIMS-1][NB] != '0;
	end

	assign res_valid = res_valid_q;
	assign pos       = pos_q;
	assign done      = done_q;

endmodule
